// File: design/dq_pkg.sv
// shared types and constants for the array based double-ended queue
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_REAR  = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_REAR  = 3'd3,
    CMD_DISPLAY   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_REAR_FULL   = 2'd1,
    ST_FRONT_FULL  = 2'd2,
    ST_EMPTY       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DISP
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   data;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// File: design/dq_ctrl.sv
// command sequencer: index bookkeeping, slot memory requests and result forming
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CMD_W-1:0]  in_cmd_i,
  input  wire logic [DATA_W-1:0] in_value_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o,
  output logic                   mem_we_o,
  output logic                   mem_re_o,
  output logic [IW-1:0]          mem_addr_o,
  output logic [DATA_W-1:0]      mem_wdata_o,
  input  wire logic [DATA_W-1:0] mem_rdata_i
);

  localparam logic [IW-1:0]    LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

  state_e           state_q, state_d;
  logic [IW-1:0]    front_q, front_d;
  logic [IW-1:0]    rear_q, rear_d;
  logic             empty_q, empty_d;
  logic [IW-1:0]    cur_q, cur_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             disp_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
      cur_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
    end
  end

  assign disp_last = (cur_q == rear_q) || (cnt_q == CNT_LAST);

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    rear_d       = rear_q;
    empty_d      = empty_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    res_o.status = ST_OK;
    res_o.data   = '0;
    res_o.last   = 1'b1;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    mem_addr_o   = '0;
    mem_wdata_o  = in_value_i;

    case (state_q)
      S_IDLE: begin
        in_ready_o = res_ready_i;
        if (in_valid_i && res_ready_i) begin
          case (cmd_e'(in_cmd_i))
            CMD_INS_REAR: begin
              res_valid_o = 1'b1;
              if (!empty_q && rear_q == LAST_IDX) begin
                res_o.status = ST_REAR_FULL;
              end else begin
                mem_we_o   = 1'b1;
                mem_addr_o = empty_q ? '0 : rear_q + 1'b1;
                rear_d     = mem_addr_o;
                empty_d    = 1'b0;
              end
            end
            CMD_INS_FRONT: begin
              res_valid_o = 1'b1;
              if (empty_q) begin
                // empty queue starts at slot zero
                mem_we_o   = 1'b1;
                mem_addr_o = '0;
                rear_d     = '0;
                empty_d    = 1'b0;
              end else if (front_q != '0) begin
                mem_we_o   = 1'b1;
                mem_addr_o = front_q - 1'b1;
                front_d    = mem_addr_o;
              end else begin
                res_o.status = ST_FRONT_FULL;
              end
            end
            CMD_DEL_FRONT: begin
              if (empty_q) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                mem_re_o   = 1'b1;
                mem_addr_o = front_q;
                state_d    = S_READ;
                if (front_q == rear_q) begin
                  empty_d = 1'b1;
                  front_d = '0;
                  rear_d  = '0;
                end else begin
                  front_d = front_q + 1'b1;
                end
              end
            end
            CMD_DEL_REAR: begin
              if (empty_q) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                mem_re_o   = 1'b1;
                mem_addr_o = rear_q;
                state_d    = S_READ;
                if (front_q == rear_q) begin
                  empty_d = 1'b1;
                  front_d = '0;
                  rear_d  = '0;
                end else begin
                  rear_d = rear_q - 1'b1;
                end
              end
            end
            CMD_DISPLAY: begin
              if (empty_q) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                mem_re_o   = 1'b1;
                mem_addr_o = front_q;
                cur_d      = front_q;
                cnt_d      = '0;
                state_d    = S_DISP;
              end
            end
            default: begin
              // undefined command codes are swallowed without a result
            end
          endcase
        end
      end
      S_READ: begin
        res_valid_o = 1'b1;
        res_o.data  = mem_rdata_i;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_DISP: begin
        res_valid_o = 1'b1;
        res_o.data  = mem_rdata_i;
        res_o.last  = disp_last;
        if (res_ready_i) begin
          if (disp_last) begin
            state_d = S_IDLE;
          end else begin
            mem_re_o   = 1'b1;
            mem_addr_o = cur_q + 1'b1;
            cur_d      = mem_addr_o;
            cnt_d      = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_empty_front_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> front_q == '0)
    else $error("empty queue with nonzero front index");

  a_front_le_rear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> front_q <= rear_q)
    else $error("front index beyond rear index");

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("slot read and write in one cycle");

  a_disp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP && !res_ready_i) |=> ($stable(cur_q) && state_q == S_DISP))
    else $error("display walk moved while stalled");

  a_disp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DISP |-> (cur_q <= rear_q && cur_q >= front_q && !empty_q))
    else $error("display pointer outside held entries");

endmodule

`default_nettype wire

// File: design/array_double_ended_queue.sv
// top level of the array based double-ended queue: slot memory, sequencer, output register
// insert and error results pass the output register and appear in the cycle after the command is taken
// deletes read their word into the slot read register, then pass it on through the output register
// display: first entry likewise, then one entry per cycle while results are not stalled, up to 32 entries
// inserts are taken one per cycle while results are not stalled; a delete or display takes no new
// command until its last word has moved on; the slot memory has a single port, one access per cycle
// reset: indices go to empty; slot memory is not cleared, and an empty queue never reads it
`timescale 1ns / 1ps
`default_nettype none

module array_double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // command stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [DATA_W-1:0]   s_axis_tdata,  // [31:0] value
  input  wire logic [CMD_W-1:0]    s_axis_tuser,  // [2:0] command
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [DATA_W-1:0]        m_axis_tdata,  // [31:0] data
  output logic [STATUS_W-1:0]      m_axis_tuser,  // [1:0] status
  output logic                     m_axis_tlast
);

  localparam int unsigned IW = $clog2(DEPTH);

  // sequencer to memory and output stage
  logic              mem_we;
  logic              mem_re;
  logic [IW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] rdata_q;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // output register
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q;

  // slot storage, one access per cycle, registered read data
  logic [DATA_W-1:0] slots_q [DEPTH];

  dq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_value_i  (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (rdata_q)
  );

  // read data only changes on a read, so it holds across output stalls
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slots_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= slots_q[mem_addr];
    end
  end

  // output stage takes a new word when empty or when its word leaves
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.data;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tlast  = out_res_q.last;

endmodule

`default_nettype wire

// File: tb/array_double_ended_queue_tb.sv
// self-checking testbench for the array based double-ended queue
`timescale 1ns / 1ps

module array_double_ended_queue_tb
  import dq_pkg::*;
();

  localparam int QUEUE_DEPTH     = 32;
  localparam int ITEM_TARGET     = 200;     // min. commands over all parts, unused codes not counted
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int TAIL_CYCLES     = 40;      // longer than a full display
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int CMD_CODES       = 1 << CMD_W;

  // software copy of the deque: slot array, indices and the words still owed
  class deque_mirror;
    logic [DATA_W-1:0] slot_mem [QUEUE_DEPTH];
    int                head_idx;
    int                tail_idx;             // -1 while empty
    res_t              pending_words [$];
    int                mismatches;
    int                words_checked;
    int                longest_display;
    int                cmd_count [CMD_CODES];
    int                status_count [1 << STATUS_W];

    function new();
      head_idx = 0;
      tail_idx = -1;
    endfunction

    function bit is_empty();
      return head_idx == 0 && tail_idx == -1;
    endfunction

    function void queue_word(status_e st, logic [DATA_W-1:0] d, logic l);
      res_t w;
      w.status = st;
      w.data   = d;
      w.last   = l;
      pending_words.push_back(w);
      status_count[st]++;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("ERROR at %0t: %s", $time, what);
    endtask

    // called once per accepted command word
    function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] d;
      int                n;
      cmd_count[cmd]++;
      case (cmd)
        CMD_INS_REAR: begin
          if (tail_idx >= QUEUE_DEPTH - 1) begin
            queue_word(ST_REAR_FULL, '0, 1'b1);
          end else begin
            tail_idx++;
            slot_mem[tail_idx] = value;
            queue_word(ST_OK, '0, 1'b1);
          end
        end
        CMD_INS_FRONT: begin
          if (is_empty()) begin
            // empty queue: value lands in slot 0
            tail_idx    = 0;
            slot_mem[0] = value;
            queue_word(ST_OK, '0, 1'b1);
          end else if (head_idx != 0) begin
            head_idx--;
            slot_mem[head_idx] = value;
            queue_word(ST_OK, '0, 1'b1);
          end else begin
            queue_word(ST_FRONT_FULL, '0, 1'b1);
          end
        end
        CMD_DEL_FRONT, CMD_DEL_REAR: begin
          if (is_empty()) begin
            queue_word(ST_EMPTY, '0, 1'b1);
          end else begin
            if (cmd == CMD_DEL_FRONT) begin
              d = slot_mem[head_idx];
              head_idx++;
            end else begin
              d = slot_mem[tail_idx];
              tail_idx--;
            end
            if (head_idx > tail_idx) begin
              head_idx = 0;
              tail_idx = -1;
            end
            queue_word(ST_OK, d, 1'b1);
          end
        end
        CMD_DISPLAY: begin
          if (is_empty()) begin
            queue_word(ST_EMPTY, '0, 1'b1);
          end else begin
            n = 0;
            for (int i = head_idx; i <= tail_idx && n < MAX_RESULTS; i++) begin
              queue_word(ST_OK, slot_mem[i], (i == tail_idx) || (n == MAX_RESULTS - 1));
              n++;
            end
            if (n > longest_display) longest_display = n;
          end
        end
        default: begin
          // unused codes are dropped by the block
        end
      endcase
    endfunction

    // called once per accepted result word
    task check_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] data, logic last);
      res_t want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word status %0d data %h last %b",
                                  status, data, last));
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (data !== want.data)
        report_mismatch($sformatf("data %h, want %h", data, want.data));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, want %b", last, want.last));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata;   // [31:0] value
  logic [CMD_W-1:0]    s_axis_tuser;   // [2:0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DATA_W-1:0]   m_axis_tdata;   // [31:0] data
  logic [STATUS_W-1:0] m_axis_tuser;   // [1:0] status
  logic                m_axis_tlast;

  deque_mirror mirror;
  int          items_sent;
  bit          src_calm;
  bit          sink_calm;
  bit          hold_off_req;
  int          cycle_count;

  array_double_ended_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("array_double_ended_queue: mismatch");
        $finish;
      end
    end
  end

  // offer one command word and hold it until taken; valid stays high afterwards unless a random gap drops it
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.note_command(cmd, value);
    if (cmd <= CMD_DISPLAY) items_sent++;
    if (!src_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(DATA_W - 1){1'b0}}};
      3:       return {1'b0, {(DATA_W - 1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_INS_REAR;
    if (r < 48) return CMD_INS_FRONT;
    if (r < 64) return CMD_DEL_FRONT;
    if (r < 80) return CMD_DEL_REAR;
    if (r < 94) return CMD_DISPLAY;
    return CMD_W'($urandom_range(CMD_DISPLAY + 1, CMD_CODES - 1));
  endfunction

  // result side: check every accepted word, stall in random bursts or on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        mirror.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !sink_calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : command_source
    int  n_front;
    int  seg_len;
    int  waited;
    int  unused_cmds;
    bit  pressure_done;
    bit  pause_done;
    bit  first_fill;
    mirror        = new();
    items_sent    = 0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    hold_off_req  = 1'b0;
    pressure_done = 1'b0;
    pause_done    = 1'b0;
    first_fill    = 1'b1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_DISPLAY;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue corners, single entry deletes, extremes of the value
    send_command(CMD_DISPLAY,   pick_value());
    send_command(CMD_DEL_FRONT, pick_value());
    send_command(CMD_DEL_REAR,  pick_value());
    send_command(CMD_INS_FRONT, 32'h8000_0000);   // empty queue goes to slot 0
    send_command(CMD_INS_FRONT, 32'h1234_5678);   // front at 0, not empty: refused
    send_command(CMD_INS_REAR,  32'h7fff_ffff);
    send_command(CMD_INS_REAR,  32'hffff_ffff);
    send_command(CMD_INS_REAR,  32'h0000_0000);
    send_command(CMD_DISPLAY,   32'h0000_0000);
    send_command(CMD_DEL_FRONT, 32'hffff_ffff);
    send_command(CMD_INS_FRONT, 32'h5555_5555);   // front above 0, so accepted
    send_command(CMD_DEL_REAR,  32'h0000_0000);
    send_command(CMD_DEL_FRONT, 32'h0000_0000);
    send_command(CMD_DEL_FRONT, 32'h0000_0000);
    send_command(CMD_DEL_REAR,  32'h0000_0000);   // front passes rear: back to empty
    send_command(CMD_DISPLAY,   32'h0000_0000);
    for (int c = CMD_DISPLAY + 1; c < CMD_CODES; c++)
      send_command(CMD_W'(c), $urandom);
    send_command(CMD_INS_REAR,  32'haaaa_aaaa);
    send_command(CMD_DEL_FRONT, 32'h0000_0000);   // single entry removed at the front
    send_command(CMD_DISPLAY,   32'h0000_0000);

    // random part: mixed runs and full-queue runs
    while (items_sent < ITEM_TARGET) begin
      if (!pressure_done && items_sent >= ITEM_TARGET / 3) begin
        // sink holds off while words keep coming, so the block backs up
        pressure_done = 1'b1;
        src_calm      = 1'b1;
        hold_off_req  = 1'b1;
        repeat (40) send_command(random_command(), pick_value());
        src_calm      = 1'b0;
      end else if (!pause_done && items_sent >= ITEM_TARGET / 2) begin
        // source goes quiet until every owed word is out
        pause_done = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (mirror.pending_words.size() != 0);
      end
      if (items_sent >= ITEM_TARGET - 40) begin
        src_calm  = 1'b1;
        sink_calm = 1'b1;
      end
      if (first_fill || $urandom_range(0, 9) < 2) begin
        // fill the rear past the last slot, then the front down to slot 0, then show all
        first_fill = 1'b0;
        repeat (QUEUE_DEPTH + 2) send_command(CMD_INS_REAR, pick_value());
        n_front = mirror.head_idx + 1;
        repeat (n_front) send_command(CMD_INS_FRONT, pick_value());
        send_command(CMD_DISPLAY, pick_value());
      end else begin
        seg_len = $urandom_range(6, 14);
        repeat (seg_len) send_command(random_command(), pick_value());
      end
    end

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (mirror.pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mirror.pending_words.size() != 0)
      mirror.report_mismatch($sformatf("%0d expected words never came",
                                       mirror.pending_words.size()));

    unused_cmds = 0;
    for (int c = CMD_DISPLAY + 1; c < CMD_CODES; c++)
      unused_cmds += mirror.cmd_count[c];
    $display("cmds: ins rear %0d, ins front %0d, del front %0d, del rear %0d, display %0d, unused %0d",
             mirror.cmd_count[CMD_INS_REAR], mirror.cmd_count[CMD_INS_FRONT],
             mirror.cmd_count[CMD_DEL_FRONT], mirror.cmd_count[CMD_DEL_REAR],
             mirror.cmd_count[CMD_DISPLAY], unused_cmds);
    $display("results: %0d checked, %0d rear full, %0d front refused, %0d empty, display max %0d",
             mirror.words_checked, mirror.status_count[ST_REAR_FULL],
             mirror.status_count[ST_FRONT_FULL], mirror.status_count[ST_EMPTY],
             mirror.longest_display);
    if (mirror.mismatches == 0) begin
      $display("array_double_ended_queue: match");
    end else begin
      $display("array_double_ended_queue: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
design/dq_pkg.sv
design/dq_ctrl.sv
design/array_double_ended_queue.sv
tb/array_double_ended_queue_tb.sv
